@@ design/kde_pkg.sv @@
// ----------------------------------------------------------------------------
// kde_pkg: shared types and constants of the keypad debounce event engine
// Key and counter widths, register indexes, event kinds and the event pair
// that travels from the classifying front end to the output side.
// ----------------------------------------------------------------------------
package kde_pkg;

  // Matrix size and field widths
  localparam int unsigned NUM_KEYS  = 64;
  localparam int unsigned KEY_W     = 6;
  localparam int unsigned KEY_NUM_W = 7;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 8;

  // Event queue depth
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGPRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_LEVEL = 3'd4;

  // Event kinds
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REPEAT  = 2'd3
  } ev_kind_e;

  // One event
  typedef struct packed {
    ev_kind_e              kind;
    logic [KEY_NUM_W-1:0]  key;
  } ev_t;

  // Events caused by one sample: first always present, second when dual
  typedef struct packed {
    ev_t  first;
    ev_t  second;
    logic dual;
  } ev_pair_t;

endpackage

@@ design/kde_front.sv @@
// ----------------------------------------------------------------------------
// kde_front: sample intake, per-key counters and event classification
// Reads the key counter on acceptance, writes it back when the sample leaves
// stage one, tracks held key and repeat countdown, and pushes the events.
// ----------------------------------------------------------------------------
module kde_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kde_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kde_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kde_pkg::KEY_W-1:0]         in_key_i,
  input  logic                              in_level_i,
  input  logic                              in_eos_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output kde_pkg::ev_pair_t                 push_data_o
);

  // Configuration registers
  logic [kde_pkg::CNT_W-1:0] debounce_q, longpress_q, rpt_delay_q, rpt_rate_q;
  logic                      act_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= 8'd3;
      longpress_q <= 8'd100;
      rpt_delay_q <= 8'd50;
      rpt_rate_q  <= 8'd10;
      act_level_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kde_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        kde_pkg::CFG_LONGPRESS: longpress_q <= cfg_data_i;
        kde_pkg::CFG_RPT_DELAY: rpt_delay_q <= cfg_data_i;
        kde_pkg::CFG_RPT_RATE:  rpt_rate_q  <= cfg_data_i;
        kde_pkg::CFG_ACT_LEVEL: act_level_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage one holds the accepted sample
  logic                        s1_valid_q;
  logic [kde_pkg::KEY_W-1:0]   s1_key_q;
  logic                        s1_level_q, s1_eos_q;
  logic                        s1_adv, accept;

  // Counter memory, its valid bits and the read/bypass registers
  logic [kde_pkg::CNT_W-1:0]    cnt_mem_q [kde_pkg::NUM_KEYS];
  logic [kde_pkg::NUM_KEYS-1:0] key_vld_q;
  logic [kde_pkg::CNT_W-1:0]    rd_cnt_q, fwd_cnt_q;
  logic                         rd_vld_q, fwd_q;

  // Held key and repeat countdown
  logic [kde_pkg::KEY_NUM_W-1:0] held_q, held_d, held_mid;
  logic [kde_pkg::CNT_W-1:0]     cd_q, cd_d, cd_mid, cd_dec;

  logic [kde_pkg::CNT_W-1:0]     cur_cnt, new_cnt;
  logic [kde_pkg::CNT_W:0]       cnt_inc;
  logic [kde_pkg::KEY_NUM_W-1:0] key_num;
  logic                          in_range, wr_en;
  logic                          key_ev, rpt_ev, has_ev;
  kde_pkg::ev_kind_e             key_kind;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = ~s1_valid_q | s1_adv;

  // Current counter value: bypass from the previous write, else memory, else zero
  assign cur_cnt = fwd_q ? fwd_cnt_q : (rd_vld_q ? rd_cnt_q : '0);
  assign cnt_inc = {1'b0, cur_cnt} + 9'd1;
  assign key_num = {1'b0, s1_key_q} + 7'd1;
  assign in_range = ({1'b0, s1_key_q} < kde_pkg::KEY_NUM_W'(kde_pkg::NUM_KEYS));

  // Classify the sample
  always_comb begin
    new_cnt  = cur_cnt;
    key_ev   = 1'b0;
    key_kind = kde_pkg::EV_PRESS;
    held_mid = held_q;
    cd_mid   = cd_q;
    if (in_range) begin
      if (s1_level_q == act_level_q) begin
        if (cnt_inc > {1'b0, longpress_q}) begin
          new_cnt = longpress_q;
        end else begin
          new_cnt = cnt_inc[kde_pkg::CNT_W-1:0];
          if (cnt_inc == {1'b0, longpress_q}) begin
            key_ev   = 1'b1;
            key_kind = kde_pkg::EV_LONG;
          end else if (cnt_inc == {1'b0, debounce_q}) begin
            key_ev   = 1'b1;
            key_kind = kde_pkg::EV_PRESS;
            held_mid = key_num;
            cd_mid   = rpt_delay_q;
          end
        end
      end else if (cur_cnt >= debounce_q) begin
        new_cnt  = '0;
        key_ev   = 1'b1;
        key_kind = kde_pkg::EV_RELEASE;
        if (held_q == key_num) begin
          held_mid = '0;
        end
      end
    end
  end

  // Step the repeat countdown at the end of a sweep
  assign cd_dec = cd_mid - 8'd1;

  always_comb begin
    held_d = held_mid;
    cd_d   = cd_mid;
    rpt_ev = 1'b0;
    if (s1_eos_q && (held_mid != '0)) begin
      if (cd_dec == '0) begin
        cd_d   = rpt_rate_q;
        rpt_ev = 1'b1;
      end else begin
        cd_d = cd_dec;
      end
    end
  end

  assign has_ev = key_ev | rpt_ev;
  assign s1_adv = s1_valid_q & (~has_ev | ~q_full_i);
  assign wr_en  = s1_adv & in_range;
  assign push_o = s1_valid_q & has_ev & ~q_full_i;

  // Pack the events of this sample
  always_comb begin
    push_data_o.dual        = key_ev & rpt_ev;
    push_data_o.second.kind = kde_pkg::EV_REPEAT;
    push_data_o.second.key  = held_mid;
    if (key_ev) begin
      push_data_o.first.kind = key_kind;
      push_data_o.first.key  = key_num;
    end else begin
      push_data_o.first.kind = kde_pkg::EV_REPEAT;
      push_data_o.first.key  = held_mid;
    end
  end

  // Advance stage one and commit held key and countdown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      held_q     <= '0;
      cd_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        held_q <= held_d;
        cd_q   <= cd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_key_q   <= in_key_i;
      s1_level_q <= in_level_i;
      s1_eos_q   <= in_eos_i;
    end
  end

  // Counter memory: write back in stage one, read on acceptance
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem_q[s1_key_q] <= new_cnt;
    end
    if (accept) begin
      rd_cnt_q  <= cnt_mem_q[in_key_i];
      fwd_cnt_q <= new_cnt;
    end
  end

  // Valid bits and same-key bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        key_vld_q[s1_key_q] <= 1'b1;
      end
      if (accept) begin
        rd_vld_q <= key_vld_q[in_key_i];
        fwd_q    <= wr_en & (s1_key_q == in_key_i);
      end
    end
  end

endmodule

@@ design/kde_queue.sv @@
// ----------------------------------------------------------------------------
// kde_queue: short event queue
// Holds event pairs between the classifying front end and the output side.
// ----------------------------------------------------------------------------
module kde_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kde_pkg::ev_pair_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output kde_pkg::ev_pair_t head_o
);

  kde_pkg::ev_pair_t                 slot_q [kde_pkg::QUEUE_DEPTH];
  logic [kde_pkg::QPTR_W-1:0]        wptr_q, rptr_q;
  logic [kde_pkg::QCNT_W-1:0]        count_q;
  logic                              do_pop;

  assign full_o       = (count_q == kde_pkg::QCNT_W'(kde_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rptr_q];
  assign do_pop       = pop_i & head_valid_o;

  // Store pushed pairs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 2'd1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 2'd1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 3'd1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 3'd1;
      end
    end
  end

endmodule

@@ design/kde_back.sv @@
// ----------------------------------------------------------------------------
// kde_back: event output stage
// Splits queued event pairs into single words and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
module kde_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  kde_pkg::ev_pair_t             head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kde_pkg::ev_kind_e             out_kind_o,
  output logic [kde_pkg::KEY_NUM_W-1:0] out_key_o,
  output logic                          out_last_o
);

  logic                          out_valid_q;
  kde_pkg::ev_t                  out_ev_q;
  logic                          out_last_q;
  logic                          sel_q;
  logic                          load, split;

  assign load  = head_valid_i & (~out_valid_q | out_ready_i);
  assign split = head_i.dual & ~sel_q;
  assign pop_o = load & ~split;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_ev_q.kind;
  assign out_key_o   = out_ev_q.key;
  assign out_last_o  = out_last_q;

  // Hold or advance the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sel_q       <= split;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ev_q   <= sel_q ? head_i.second : head_i.first;
      out_last_q <= ~split;
    end
  end

endmodule

@@ design/keypad_debounce_event_engine_top.sv @@
// ----------------------------------------------------------------------------
// keypad_debounce_event_engine_top: keypad debounce and event engine
// Takes sampled key levels from a matrix scan and reports press, long press,
// release and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one word per sampled key. tdata carries the key index and
//   the pin level, tlast marks the last key of a full matrix sweep.
//   Output stream: one word per event. tuser is the event kind, tdata the key
//   number (index plus one), tlast marks the last event of one sample.
//   Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
//   high; write only while no sample is in flight.
//   Throughput: one sample per cycle while the output keeps up; each sample
//   gives zero, one or two event words, and the output port moves one word a
//   cycle while tready is high. A bypass forwards each counter write-back, so
//   back-to-back samples of one key see the updated count. Events pass
//   from stage one through the queue into the output register.
//   Reset: all key counters read as zero (per-key valid bits), no key held,
//   countdown zero, registers at their defaults. No clearing pass is needed.
//   Stall: when the receiver holds tready low, events collect in a four-entry
//   queue; once it fills, s_axis_tready drops until words drain.
// ----------------------------------------------------------------------------
module keypad_debounce_event_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kde_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kde_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [5:0] key_index, [6] pin_level
  input  logic                          s_axis_tlast,  // end_of_sweep
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [6:0] key_number
  output logic [1:0]                    m_axis_tuser,  // [1:0] event_kind
  output logic                          m_axis_tlast   // last
);

  logic                          q_full, push, head_valid, pop;
  kde_pkg::ev_pair_t             push_data, head;
  kde_pkg::ev_kind_e             out_kind;
  logic [kde_pkg::KEY_NUM_W-1:0] out_key;

  // Intake and classification
  kde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_key_i    (s_axis_tdata[5:0]),
    .in_level_i  (s_axis_tdata[6]),
    .in_eos_i    (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Event queue
  kde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Output words
  kde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (out_kind),
    .out_key_o    (out_key),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {1'b0, out_key};

endmodule
